FILE: hdl/crml_pkg.sv
// crml_pkg: constants, widths and helper functions for the controller range mapper
// no dependencies; imported by the divider, multiplier, square root, log2 and top-level modules
package crml_pkg;

    localparam int Z_W     = 26;  // normalized value, unsigned Q2.24
    localparam int MUL_A_W = 34;  // signed multiplicand of the serial multiplier
    localparam int MUL_B_W = 26;  // unsigned multiplier of the serial multiplier
    localparam int MUL_P_W = 61;  // signed product
    localparam int LOG_W   = 29;  // log2 result, unsigned Q5.24

    localparam logic [12:0] DIV_7BIT  = 13'd127;
    localparam logic [12:0] DIV_BEND  = 13'd8191;
    localparam logic [12:0] HALF_7BIT = 13'd63;
    localparam logic [12:0] HALF_BEND = 13'd4095;
    localparam logic [13:0] RAW_7BIT_MAX = 14'd127;

    localparam logic [1:0] REG_MAP_MODE    = 2'd0;
    localparam logic [1:0] REG_VALUE_SCALE = 2'd1;
    localparam logic [1:0] REG_LAG_COEF    = 2'd2;

    localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

    function automatic logic signed [31:0] sat32(input logic signed [61:0] v);
        logic signed [31:0] r;
        if (v > 62'(Q_MAX))
            r = Q_MAX;
        else if (v < 62'(Q_MIN))
            r = Q_MIN;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

FILE: hdl/crml_if.sv
// crml_if: valid/ready channel interfaces for input items and result items
// uses no package
interface crml_in_if;
    logic               valid;
    logic               ready;
    logic        [13:0] raw_value;
    logic signed [31:0] low_bound;
    logic signed [31:0] high_bound;

    modport source (output valid, raw_value, low_bound, high_bound, input ready);
    modport sink (input valid, raw_value, low_bound, high_bound, output ready);
endinterface

interface crml_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] out_value;
    logic               domain_error;

    modport source (output valid, out_value, domain_error, input ready);
    modport sink (input valid, out_value, domain_error, output ready);
endinterface

FILE: hdl/crml_div.sv
// crml_div: bit-serial restoring divider, raw value by 127 or 8191 into Q2.24
// depends on crml_pkg
module crml_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [13:0]               raw_value,
    input  logic                      value_scale,
    output logic                      done,
    output logic [crml_pkg::Z_W-1:0]  z
);
    import crml_pkg::*;

    localparam int NUM_W = 38;

    logic [NUM_W-1:0] num_reg, num_next;
    logic [12:0]      rem_reg, rem_next;
    logic [12:0]      dvs_reg, dvs_next;
    logic [Z_W-1:0]   q_reg, q_next;
    logic [5:0]       cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [13:0]      raw_sat;
    logic [13:0]      trial;

    always_comb
    begin
        raw_sat = (!value_scale && raw_value > RAW_7BIT_MAX) ? RAW_7BIT_MAX : raw_value;
        trial = {rem_reg, num_reg[NUM_W-1]};
        num_next  = num_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            num_next  = {raw_sat, 24'd0} + {25'd0, (value_scale ? HALF_BEND : HALF_7BIT)};
            dvs_next  = value_scale ? DIV_BEND : DIV_7BIT;
            rem_next  = '0;
            q_next    = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[NUM_W-2:0], 1'b0};
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = 13'(trial - {1'b0, dvs_reg});
                q_next   = {q_reg[Z_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[12:0];
                q_next   = {q_reg[Z_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'(NUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        q_reg   <= q_next;
    end

    assign done = done_reg;
    assign z    = q_reg;

endmodule

FILE: hdl/crml_mul.sv
// crml_mul: bit-serial shift-add multiplier, signed multiplicand by unsigned multiplier
// depends on crml_pkg; takes 16 or 26 multiplier bits, one per cycle
module crml_mul (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic                                short_mode,
    input  logic signed [crml_pkg::MUL_A_W-1:0] a,
    input  logic        [crml_pkg::MUL_B_W-1:0] b,
    output logic                                done,
    output logic signed [crml_pkg::MUL_P_W-1:0] prod
);
    import crml_pkg::*;

    logic signed [MUL_P_W-1:0] acc_reg, acc_next;
    logic signed [MUL_A_W-1:0] a_reg, a_next;
    logic [MUL_B_W-1:0]        b_reg, b_next;
    logic [4:0]                cnt_reg, cnt_next;
    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;
    logic signed [MUL_P_W-1:0] a_ext;

    always_comb
    begin
        a_ext     = MUL_P_W'(a_reg);
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            acc_next  = '0;
            a_next    = a;
            // left-align a short multiplier so its msb sits on top
            b_next    = short_mode ? {b[15:0], (MUL_B_W - 16)'(0)} : b;
            cnt_next  = short_mode ? 5'd15 : 5'(MUL_B_W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next = (acc_reg <<< 1) + (b_reg[MUL_B_W-1] ? a_ext : '0);
            b_next   = {b_reg[MUL_B_W-2:0], 1'b0};
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

FILE: hdl/crml_sqrt.sv
// crml_sqrt: digit-serial integer square root, two radicand bits per cycle
// depends on crml_pkg; 64-bit radicand, 32-bit floor root
module crml_sqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] rad,
    output logic        done,
    output logic [31:0] root
);
    import crml_pkg::*;

    logic [63:0] rad_reg, rad_next;
    logic [33:0] rem_reg, rem_next;
    logic [31:0] root_reg, root_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [35:0] t;
    logic [35:0] trial;

    always_comb
    begin
        t     = {rem_reg, rad_reg[63:62]};
        trial = {2'b00, root_reg, 2'b01};
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rad_next  = rad;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = 5'd31;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rad_next = {rad_reg[61:0], 2'b00};
            if (t >= trial)
            begin
                rem_next  = 34'(t - trial);
                root_next = {root_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next  = t[33:0];
                root_next = {root_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

FILE: hdl/crml_log2.sv
// crml_log2: log2 of a positive Q16.16 word plus 16, in Q5.24, one fraction bit per squaring
// depends on crml_pkg; normalizes one bit a cycle, then 24 square-and-test steps
module crml_log2 (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [30:0]                      v,
    output logic                             done,
    output logic [crml_pkg::LOG_W-1:0]       l
);
    import crml_pkg::*;

    typedef enum logic [1:0] {L_IDLE, L_NORM, L_MUL, L_STEP} log_state_t;

    log_state_t  state_reg;
    logic [31:0] x_reg;
    logic [4:0]  top_reg;
    logic [23:0] frac_reg;
    logic [4:0]  cnt_reg;
    logic [61:0] prod_reg;
    logic        done_reg;
    logic [31:0] p;

    assign p = prod_reg[61:30];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            done_reg  <= 1'b0;
            x_reg     <= '0;
            top_reg   <= '0;
            frac_reg  <= '0;
            cnt_reg   <= '0;
            prod_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                L_IDLE:
                begin
                    if (start)
                    begin
                        x_reg     <= {1'b0, v};
                        top_reg   <= 5'd30;
                        frac_reg  <= '0;
                        cnt_reg   <= '0;
                        state_reg <= L_NORM;
                    end
                end
                L_NORM:
                begin
                    if (x_reg[30])
                        state_reg <= L_MUL;
                    else
                    begin
                        x_reg   <= {x_reg[30:0], 1'b0};
                        top_reg <= top_reg - 5'd1;
                    end
                end
                L_MUL:
                begin
                    prod_reg  <= 62'(x_reg[30:0]) * 62'(x_reg[30:0]);
                    state_reg <= L_STEP;
                end
                L_STEP:
                begin
                    // square reached 2 or more: fraction bit is one, halve back
                    frac_reg <= {frac_reg[22:0], p[31]};
                    x_reg    <= p[31] ? {1'b0, p[31:1]} : p;
                    cnt_reg  <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd23)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= L_IDLE;
                    end
                    else
                        state_reg <= L_MUL;
                end
                default:
                    state_reg <= L_IDLE;
            endcase
        end
    end

    assign done = done_reg;
    assign l    = {top_reg, frac_reg};

endmodule

FILE: hdl/controller_range_map_lag.sv
// controller range mapper with one-pole lag, one result item per input item
// linear mode: divide, map multiply, then lag multiply and output
// exponential mode: divide, log2 of both bounds, multiply, up to 24 serial square roots, shift, lag multiply
// one item at a time: the next item is taken after this one reaches the output register
// reset clears the configuration registers, the lag memory and the output valid
module controller_range_map_lag (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  logic [1:0]        cfg_index,
    input  logic [15:0]       cfg_data,
    crml_in_if.sink           in_ch,
    crml_out_if.source        out_ch
);
    import crml_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DIV, S_LMUL, S_LOGLO, S_LOGHI, S_EMUL,
        S_EXPB, S_EXPW, S_EXPSH, S_LAGS, S_LAGW, S_DONE
    } state_t;

    state_t             state_reg;
    logic               map_mode_reg;
    logic               value_scale_reg;
    logic [15:0]        lag_coef_reg;

    logic [13:0]        raw_reg;
    logic signed [31:0] lo_reg, hi_reg;
    logic [Z_W-1:0]     z_reg;
    logic [LOG_W-1:0]   llo_reg;
    logic [23:0]        f_reg;
    logic signed [7:0]  ip_reg;
    logic [4:0]         bit_reg;
    logic [31:0]        r_reg;
    logic [5:0]         sh_reg;
    logic signed [31:0] y0_reg;
    logic               err_reg;
    logic signed [31:0] lag_mem_reg;
    logic signed [31:0] res_reg;

    logic               out_valid_reg;
    logic signed [31:0] out_value_reg;
    logic               out_err_reg;

    logic               div_start_reg, mul_start_reg, log_start_reg, sqrt_start_reg;
    logic               mul_short_reg;
    logic signed [MUL_A_W-1:0] mul_a_reg;
    logic [MUL_B_W-1:0] mul_b_reg;
    logic [30:0]        log_v_reg;
    logic [63:0]        sqrt_rad_reg;

    logic               div_done, mul_done, log_done, sqrt_done;
    logic [Z_W-1:0]     div_z;
    logic signed [MUL_P_W-1:0] prod;
    logic [LOG_W-1:0]   log_l;
    logic [31:0]        sqrt_root;

    logic signed [MUL_P_W-1:0] rnd24, rnd16;
    logic signed [31:0] lin_y0;
    logic signed [31:0] e_val;
    logic signed [7:0]  ip_val;
    logic signed [8:0]  s_val;
    logic signed [31:0] lag_y;
    logic [32:0]        r_sel;

    crml_div u_div (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (div_start_reg),
        .raw_value   (raw_reg),
        .value_scale (value_scale_reg),
        .done        (div_done),
        .z           (div_z)
    );

    crml_mul u_mul (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (mul_start_reg),
        .short_mode (mul_short_reg),
        .a          (mul_a_reg),
        .b          (mul_b_reg),
        .done       (mul_done),
        .prod       (prod)
    );

    crml_log2 u_log (
        .clk   (clk),
        .rst_n (rst_n),
        .start (log_start_reg),
        .v     (log_v_reg),
        .done  (log_done),
        .l     (log_l)
    );

    crml_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start_reg),
        .rad   (sqrt_rad_reg),
        .done  (sqrt_done),
        .root  (sqrt_root)
    );

    always_comb
    begin
        rnd24  = (prod + (MUL_P_W'(1) <<< 23)) >>> 24;
        rnd16  = (prod + (MUL_P_W'(1) <<< 15)) >>> 16;
        lin_y0 = sat32(62'(lo_reg) + 62'(rnd24));
        e_val  = $signed({3'b000, llo_reg}) + 32'(rnd24);
        ip_val = e_val[31:24];
        s_val  = 9'sd30 - 9'(ip_val);
        lag_y  = sat32(62'(y0_reg) + 62'(rnd16));
        // next mantissa bit set: double before the root
        r_sel  = f_reg[0] ? {r_reg, 1'b0} : {1'b0, r_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_mode_reg    <= 1'b0;
            value_scale_reg <= 1'b0;
            lag_coef_reg    <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_MAP_MODE:    map_mode_reg    <= cfg_data[0];
                REG_VALUE_SCALE: value_scale_reg <= cfg_data[0];
                REG_LAG_COEF:    lag_coef_reg    <= cfg_data;
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            div_start_reg  <= 1'b0;
            mul_start_reg  <= 1'b0;
            log_start_reg  <= 1'b0;
            sqrt_start_reg <= 1'b0;
            mul_short_reg  <= 1'b0;
            mul_a_reg      <= '0;
            mul_b_reg      <= '0;
            log_v_reg      <= '0;
            sqrt_rad_reg   <= '0;
            raw_reg        <= '0;
            lo_reg         <= '0;
            hi_reg         <= '0;
            z_reg          <= '0;
            llo_reg        <= '0;
            f_reg          <= '0;
            ip_reg         <= '0;
            bit_reg        <= '0;
            r_reg          <= '0;
            sh_reg         <= '0;
            y0_reg         <= '0;
            err_reg        <= 1'b0;
            lag_mem_reg    <= '0;
            res_reg        <= '0;
            out_valid_reg  <= 1'b0;
            out_value_reg  <= '0;
            out_err_reg    <= 1'b0;
        end
        else
        begin
            div_start_reg  <= 1'b0;
            mul_start_reg  <= 1'b0;
            log_start_reg  <= 1'b0;
            sqrt_start_reg <= 1'b0;
            if (out_valid_reg && out_ch.ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (in_ch.valid)
                    begin
                        raw_reg       <= in_ch.raw_value;
                        lo_reg        <= in_ch.low_bound;
                        hi_reg        <= in_ch.high_bound;
                        err_reg       <= 1'b0;
                        div_start_reg <= 1'b1;
                        state_reg     <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        z_reg <= div_z;
                        if (!map_mode_reg)
                        begin
                            mul_a_reg     <= MUL_A_W'(hi_reg) - MUL_A_W'(lo_reg);
                            mul_b_reg     <= div_z;
                            mul_short_reg <= 1'b0;
                            mul_start_reg <= 1'b1;
                            state_reg     <= S_LMUL;
                        end
                        else if (lo_reg <= 0 || hi_reg <= 0)
                        begin
                            err_reg   <= 1'b1;
                            y0_reg    <= lo_reg;
                            state_reg <= S_LAGS;
                        end
                        else if (div_z == '0)
                        begin
                            y0_reg    <= lo_reg;
                            state_reg <= S_LAGS;
                        end
                        else
                        begin
                            log_v_reg     <= lo_reg[30:0];
                            log_start_reg <= 1'b1;
                            state_reg     <= S_LOGLO;
                        end
                    end
                end
                S_LMUL:
                begin
                    if (mul_done)
                    begin
                        y0_reg    <= lin_y0;
                        state_reg <= S_LAGS;
                    end
                end
                S_LOGLO:
                begin
                    if (log_done)
                    begin
                        llo_reg       <= log_l;
                        log_v_reg     <= hi_reg[30:0];
                        log_start_reg <= 1'b1;
                        state_reg     <= S_LOGHI;
                    end
                end
                S_LOGHI:
                begin
                    if (log_done)
                    begin
                        mul_a_reg     <= MUL_A_W'({1'b0, log_l}) - MUL_A_W'({1'b0, llo_reg});
                        mul_b_reg     <= z_reg;
                        mul_short_reg <= 1'b0;
                        mul_start_reg <= 1'b1;
                        state_reg     <= S_EMUL;
                    end
                end
                S_EMUL:
                begin
                    if (mul_done)
                    begin
                        if (ip_val >= 8'sd31)
                        begin
                            y0_reg    <= Q_MAX;
                            state_reg <= S_LAGS;
                        end
                        else
                        begin
                            f_reg     <= e_val[23:0];
                            ip_reg    <= ip_val;
                            r_reg     <= 32'h4000_0000;
                            bit_reg   <= '0;
                            state_reg <= S_EXPB;
                        end
                    end
                end
                S_EXPB:
                begin
                    sqrt_rad_reg   <= {1'b0, r_sel, 30'd0};
                    sqrt_start_reg <= 1'b1;
                    f_reg          <= {1'b0, f_reg[23:1]};
                    state_reg      <= S_EXPW;
                end
                S_EXPW:
                begin
                    if (sqrt_done)
                    begin
                        r_reg   <= sqrt_root;
                        bit_reg <= bit_reg + 5'd1;
                        if (bit_reg == 5'd23)
                        begin
                            if (ip_reg == 8'sd30)
                            begin
                                y0_reg    <= sqrt_root;
                                state_reg <= S_LAGS;
                            end
                            else
                            begin
                                // shifts beyond 32 leave zero anyway
                                sh_reg    <= (s_val > 9'sd33) ? 6'd32 : 6'(s_val - 9'sd1);
                                state_reg <= S_EXPSH;
                            end
                        end
                        else
                            state_reg <= S_EXPB;
                    end
                end
                S_EXPSH:
                begin
                    if (sh_reg != '0)
                    begin
                        r_reg  <= {1'b0, r_reg[31:1]};
                        sh_reg <= sh_reg - 6'd1;
                    end
                    else
                    begin
                        // last step rounds half up
                        y0_reg    <= $signed(32'((33'(r_reg) + 33'd1) >> 1));
                        state_reg <= S_LAGS;
                    end
                end
                S_LAGS:
                begin
                    mul_a_reg     <= MUL_A_W'(lag_mem_reg) - MUL_A_W'(y0_reg);
                    mul_b_reg     <= MUL_B_W'(lag_coef_reg);
                    mul_short_reg <= 1'b1;
                    mul_start_reg <= 1'b1;
                    state_reg     <= S_LAGW;
                end
                S_LAGW:
                begin
                    if (mul_done)
                    begin
                        lag_mem_reg <= lag_y;
                        res_reg     <= lag_y;
                        state_reg   <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (!out_valid_reg || out_ch.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_value_reg <= res_reg;
                        out_err_reg   <= err_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_ch.ready         = (state_reg == S_IDLE);
    assign out_ch.valid        = out_valid_reg;
    assign out_ch.out_value    = out_value_reg;
    assign out_ch.domain_error = out_err_reg;

endmodule

FILE: hdl/crml_checker.sv
// crml_checker: port-level checks on the controller range mapper, bound to the top level
// depends on controller_range_map_lag ports only
module crml_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] out_value,
    input logic        out_error,
    input logic        cfg_write
);

    // valid clears during reset
    a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("output valid set after reset");

    // one item at a time: an accepted item closes the input
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input still open after an item was accepted");

    // a result that stalls keeps its value
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_error))
        else $error("stalled result changed");

    // a new result only follows a busy interval, never an idle cycle in which no item was offered
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready && !in_valid && !cfg_write && !out_valid |=> !out_valid)
        else $error("result appeared with no item in flight");

endmodule

bind controller_range_map_lag crml_checker u_crml_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_value (out_ch.out_value),
    .out_error (out_ch.domain_error),
    .cfg_write (cfg_write)
);
